>>> hdl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_front, ffha_back and first_fit_heap_allocator; no dependencies.
package ffha_pkg;

    localparam int ADDR_W          = 48;
    localparam int REQ_W           = 17;
    localparam int BYTES_W         = 17;
    localparam int COUNT_W         = 12;
    localparam int STATUS_W        = 2;

    localparam int GRANULE_BYTES   = 16;
    localparam int GRAN_SHIFT      = 4;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int MIN_GRAN        = MIN_BLOCK_BYTES / GRANULE_BYTES;
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_GRAN_SHIFT = 8;
    localparam int HDR_OFFSET      = 8;
    localparam int HDR_EXTRA       = 12;

    // granule count of the largest request, and widest block index carried
    localparam int REQ_GRAN_W      = 14;
    localparam int CMD_IDX_W       = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_PAGES = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] release_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   payload_address;
        logic [STATUS_W-1:0] status;
        logic [BYTES_W-1:0]  used_bytes;
        logic [BYTES_W-1:0]  free_bytes;
        logic [COUNT_W-1:0]  alloc_count;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic                  is_free;
        logic                  reject;
        logic [REQ_GRAN_W-1:0] need_gran;
        logic [CMD_IDX_W-1:0]  block;
    } cmd_t;

endpackage

>>> hdl/ffha_front.sv
// Front end: rounds allocate sizes, checks free addresses, queues commands.
// Depends on ffha_pkg.
module ffha_front
    import ffha_pkg::*;
#(
    parameter int GW = 13
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_item_t          request,
    input  logic [ADDR_W-1:0] heap_base,
    input  logic [GW-1:0]     heap_granules,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    localparam int UW = GW + GRAN_SHIFT;

    cmd_t              fifo_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    logic [REQ_W:0]    sz8;
    logic [REQ_W:0]    need;
    logic [REQ_W:0]    gsum;
    logic [ADDR_W-1:0] off;
    logic [UW-1:0]     total;
    logic              free_bad;
    logic              do_push;
    logic              do_pop;
    cmd_t              cls;

    always_comb
    begin
        sz8   = ({1'b0, request.request_bytes} + (REQ_W+1)'(7)) & ~(REQ_W+1)'(7);
        need  = sz8 + (REQ_W+1)'(HDR_EXTRA);
        gsum  = need + (REQ_W+1)'(GRANULE_BYTES - 1);
        off   = request.release_address - heap_base - ADDR_W'(HDR_OFFSET);
        total = {heap_granules, {GRAN_SHIFT{1'b0}}};
        free_bad = (request.release_address == '0) || (off >= ADDR_W'(total))
                   || (off[GRAN_SHIFT-1:0] != '0);

        cls.is_free   = (request.opcode == OP_FREE);
        cls.need_gran = REQ_GRAN_W'(gsum >> GRAN_SHIFT);
        if (cls.need_gran < REQ_GRAN_W'(MIN_GRAN))
        begin
            cls.need_gran = REQ_GRAN_W'(MIN_GRAN);
        end
        cls.block  = CMD_IDX_W'(off >> GRAN_SHIFT);
        cls.reject = cls.is_free ? free_bad : (request.request_bytes == '0);
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> hdl/ffha_back.sv
// Back end: walks the block tag memory, splits and merges blocks, keeps counters.
// Depends on ffha_pkg.
module ffha_back
    import ffha_pkg::*;
#(
    parameter int IDX_W = 12,
    parameter int GW    = 13
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    input  logic [ADDR_W-1:0] heap_base,
    input  logic [GW-1:0]     heap_granules,
    input  logic              reinit,
    input  logic              pop,
    output logic              empty,
    output out_item_t         result
);

    localparam int SLOTS = 1 << IDX_W;
    localparam int TAG_W = GW + 1;
    localparam int UW    = GW + GRAN_SHIFT;
    localparam int CW    = ((GW > REQ_GRAN_W) ? GW : REQ_GRAN_W) + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_A_ISSUE = 4'd1;
    localparam logic [3:0] S_A_CHECK = 4'd2;
    localparam logic [3:0] S_A_SPLIT = 4'd3;
    localparam logic [3:0] S_F_WALK  = 4'd4;
    localparam logic [3:0] S_F_STEP  = 4'd5;
    localparam logic [3:0] S_F_BLOCK = 4'd6;
    localparam logic [3:0] S_F_NEXT  = 4'd7;
    localparam logic [3:0] S_F_PREV  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [TAG_W-1:0]    mem [SLOTS];
    logic [TAG_W-1:0]    rdata_reg;

    logic [3:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [GW-1:0]       cur_reg, cur_next;
    logic [GW-1:0]       prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic [GW-1:0]       bs_reg, bs_next;
    logic                next_ok_reg, next_ok_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [UW-1:0]       used_reg, used_next;
    logic [COUNT_W-1:0]  live_reg, live_next;
    logic                init_reg, init_next;
    logic                ovr_reg, ovr_next;
    out_item_t           res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic                rd_en;
    logic [IDX_W-1:0]    raddr;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [TAG_W-1:0]    wdata;
    logic [TAG_W-1:0]    tag_q;
    logic [GW-1:0]       t_size;
    logic                t_used;
    logic [GW-1:0]       ag;
    logic [GW-1:0]       blk;
    logic [GW-1:0]       nxt;
    logic [GW-1:0]       merged;
    logic [UW-1:0]       total;
    logic                res_load;

    // tag 0 reads as one free block spanning the heap until first written
    assign tag_q  = ovr_reg ? {heap_granules, 1'b0} : rdata_reg;
    assign t_size = tag_q[TAG_W-1:1];
    assign t_used = tag_q[0];
    assign ag     = GW'(cmd_reg.need_gran);
    assign blk    = GW'(cmd_reg.block);
    assign nxt    = cur_reg + t_size;
    assign merged = bs_reg + ((next_ok_reg && !t_used) ? t_size : '0);
    assign total  = {heap_granules, {GRAN_SHIFT{1'b0}}};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        bs_next        = bs_reg;
        next_ok_next   = next_ok_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        used_next      = used_reg;
        live_next      = live_reg;
        rd_en          = 1'b0;
        raddr          = cur_reg[IDX_W-1:0];
        we             = 1'b0;
        waddr          = cur_reg[IDX_W-1:0];
        wdata          = '0;
        cmd_pop        = 1'b0;
        res_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd;
                    cur_next       = '0;
                    have_prev_next = 1'b0;
                    addr_next      = '0;
                    if (cmd.reject)
                    begin
                        status_next = cmd.is_free ? ST_IGNORED : ST_FAIL;
                        state_next  = S_DONE;
                    end
                    else if (cmd.is_free)
                    begin
                        state_next = S_F_WALK;
                    end
                    else
                    begin
                        state_next = S_A_ISSUE;
                    end
                end
            end
            S_A_ISSUE:
            begin
                if (cur_reg >= heap_granules)
                begin
                    status_next = ST_FAIL;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_A_CHECK;
                end
            end
            S_A_CHECK:
            begin
                if (t_size == '0)
                begin
                    status_next = ST_FAIL;
                    state_next  = S_DONE;
                end
                else if (!t_used && (CW'(t_size) >= CW'(cmd_reg.need_gran)))
                begin
                    status_next = ST_DONE;
                    live_next   = live_reg + COUNT_W'(1);
                    addr_next   = heap_base + (ADDR_W'(cur_reg) << GRAN_SHIFT)
                                  + ADDR_W'(HDR_OFFSET);
                    we          = 1'b1;
                    if (CW'(t_size) >= CW'(cmd_reg.need_gran) + CW'(MIN_GRAN))
                    begin
                        // remainder becomes a free block; this block is tagged next cycle
                        waddr      = IDX_W'(cur_reg + ag);
                        wdata      = {t_size - ag, 1'b0};
                        used_next  = used_reg + (UW'(ag) << GRAN_SHIFT);
                        state_next = S_A_SPLIT;
                    end
                    else
                    begin
                        wdata      = {t_size, 1'b1};
                        used_next  = used_reg + (UW'(t_size) << GRAN_SHIFT);
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cur_next   = nxt;
                    state_next = S_A_ISSUE;
                end
            end
            S_A_SPLIT:
            begin
                we         = 1'b1;
                wdata      = {ag, 1'b1};
                state_next = S_DONE;
            end
            S_F_WALK:
            begin
                if (cur_reg < blk)
                begin
                    rd_en      = 1'b1;
                    state_next = S_F_STEP;
                end
                else if (cur_reg != blk)
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_F_BLOCK;
                end
            end
            S_F_STEP:
            begin
                if (t_size == '0)
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else
                begin
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    cur_next       = nxt;
                    state_next     = S_F_WALK;
                end
            end
            S_F_BLOCK:
            begin
                if (!t_used)
                begin
                    status_next = ST_IGNORED;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next  = ST_DONE;
                    bs_next      = t_size;
                    used_next    = used_reg - (UW'(t_size) << GRAN_SHIFT);
                    live_next    = live_reg - COUNT_W'(1);
                    next_ok_next = (nxt < heap_granules);
                    rd_en        = (nxt < heap_granules);
                    raddr        = nxt[IDX_W-1:0];
                    state_next   = S_F_NEXT;
                end
            end
            S_F_NEXT:
            begin
                we      = 1'b1;
                wdata   = {merged, 1'b0};
                bs_next = merged;
                if (have_prev_reg)
                begin
                    rd_en      = 1'b1;
                    raddr      = prev_reg[IDX_W-1:0];
                    state_next = S_F_PREV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_PREV:
            begin
                if (!t_used)
                begin
                    we    = 1'b1;
                    waddr = prev_reg[IDX_W-1:0];
                    wdata = {t_size + bs_reg, 1'b0};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold here while the previous result is still waiting
                if (!res_valid_reg || pop)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (reinit)
        begin
            used_next = '0;
            live_next = '0;
        end
    end

    always_comb
    begin
        init_next = init_reg;
        if (we && (waddr == '0))
        begin
            init_next = 1'b0;
        end
        if (reinit)
        begin
            init_next = 1'b1;
        end
        ovr_next = init_reg && rd_en && (raddr == '0);

        res_next                 = res_reg;
        res_next.payload_address = addr_reg;
        res_next.status          = status_reg;
        res_next.used_bytes      = BYTES_W'(used_reg);
        res_next.free_bytes      = BYTES_W'(total - used_reg);
        res_next.alloc_count     = live_reg;

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            live_reg      <= '0;
            init_reg      <= 1'b1;
            ovr_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            init_reg      <= init_next;
            ovr_reg       <= ovr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        bs_reg        <= bs_next;
        next_ok_reg   <= next_ok_next;
        status_reg    <= status_next;
        addr_reg      <= addr_next;
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

`ifndef SYNTHESIS
    a_used_within_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (used_reg <= total))
        else $error("used bytes exceed heap size");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (GW'(waddr) < heap_granules))
        else $error("tag write outside heap");

    a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || pop))
        else $error("result overwritten before transfer");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != S_IDLE))
        else $error("command taken without starting work");
`endif

endmodule

>>> hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: configuration registers and the
// front/back split. Depends on ffha_pkg, ffha_front and ffha_back.

// First-fit allocator over heap_pages 4 KiB pages, kept as a chain of block tags
// in a tag memory of MAX_PAGES*256 entries read at one address per cycle.
// Requests enter a two-entry command queue and are executed one at a time. Each
// block walked past takes a memory read, then a check. An allocate that splits
// its block writes the free remainder, then tags the allocated block; a free
// reads the target block, writes it merged with a free next block, then merges
// it into the previous block when that one exists and is free. Rejected
// requests skip the walk. The back end finishes an item only once the
// previous result has been popped. Write configuration only while nothing is
// in flight. No clearing pass is needed after reset or after writing heap_pages.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_PAGES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_item_t          request,
    output logic              empty,
    input  logic              pop,
    output out_item_t         result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_data
);

    localparam int SLOTS = MAX_PAGES << PAGE_GRAN_SHIFT;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int GW    = IDX_W + 1;

    logic [ADDR_W-1:0] heap_base_reg;
    logic [4:0]        heap_pages_reg;
    logic [8:0]        pages_eff;
    logic [GW-1:0]     heap_granules;
    logic              cfg_write;
    logic              reinit;
    logic              cmd_valid;
    logic              cmd_pop;
    cmd_t              cmd;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign reinit    = cfg_write && (cfg_index == REG_HEAP_PAGES);

    always_comb
    begin
        pages_eff = (9'(heap_pages_reg) > 9'(MAX_PAGES)) ? 9'(MAX_PAGES)
                                                         : 9'(heap_pages_reg);
        heap_granules = GW'({8'b0, pages_eff} << PAGE_GRAN_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_pages_reg <= 5'd16;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_HEAP_BASE)
            begin
                heap_base_reg <= cfg_data;
            end
            else
            begin
                heap_pages_reg <= cfg_data[4:0];
            end
        end
    end

    ffha_front #(
        .GW (GW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .request       (request),
        .heap_base     (heap_base_reg),
        .heap_granules (heap_granules),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    ffha_back #(
        .IDX_W (IDX_W),
        .GW    (GW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .heap_base     (heap_base_reg),
        .heap_granules (heap_granules),
        .reinit        (reinit),
        .pop           (pop),
        .empty         (empty),
        .result        (result)
    );

endmodule

>>> verif/ffha_checker.sv
// Checker for the first-fit heap allocator: watches the request, result and
// configuration transfers, predicts each result and compares. Depends on ffha_pkg.
module ffha_checker
    import ffha_pkg::*;
#(
    parameter int MAX_PAGES = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  in_item_t          request,
    input  logic              empty,
    input  logic              pop,
    input  out_item_t         result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending
);

    localparam int SLOTS = MAX_PAGES * PAGE_BYTES / GRANULE_BYTES;

    // tag: size in granules and used mark, one per block start
    int unsigned      tag_gran [SLOTS];
    bit               tag_used [SLOTS];
    int unsigned      used_sum;
    int unsigned      live;
    logic [ADDR_W-1:0] base;
    int unsigned      span;
    out_item_t        expected_results[$];

    assign pending = expected_results.size();

    task automatic heap_reinit(input int unsigned pages);
        int unsigned p;
        p = pages > MAX_PAGES ? MAX_PAGES : pages;
        span = p * PAGE_BYTES / GRANULE_BYTES;
        used_sum = 0;
        live = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tag_gran[i] = 0;
            tag_used[i] = 0;
        end
        if (span > 0)
            tag_gran[0] = span;
    endtask

    task automatic try_alloc(input int unsigned size, output logic [1:0] st,
                             output logic [ADDR_W-1:0] addr);
        int unsigned need, ag, cur, bs;
        addr = '0;
        st = ST_FAIL;
        if (size == 0)
            return;
        need = ((size + 7) / 8) * 8 + HDR_EXTRA;
        ag = (need + GRANULE_BYTES - 1) / GRANULE_BYTES;
        if (ag < MIN_GRAN)
            ag = MIN_GRAN;
        cur = 0;
        while (cur < span)
        begin
            bs = tag_gran[cur];
            if (bs == 0)
                break;
            if (!tag_used[cur] && bs >= ag)
            begin
                if (bs >= ag + MIN_GRAN)
                begin
                    tag_gran[cur + ag] = bs - ag;
                    tag_used[cur + ag] = 0;
                    tag_gran[cur] = ag;
                end
                tag_used[cur] = 1;
                used_sum += tag_gran[cur] * GRANULE_BYTES;
                live++;
                addr = base + ADDR_W'(cur * GRANULE_BYTES) + ADDR_W'(HDR_OFFSET);
                st = ST_DONE;
                return;
            end
            cur += bs;
        end
    endtask

    task automatic try_release(input logic [ADDR_W-1:0] addr, output logic [1:0] st);
        logic [ADDR_W-1:0] off;
        int unsigned b, cur, prev, s, bs, n;
        bit have_prev;
        st = ST_IGNORED;
        if (addr == 0)
            return;
        off = addr - base - ADDR_W'(HDR_OFFSET);
        if (off >= ADDR_W'(span * GRANULE_BYTES) || off[3:0] != 0)
            return;
        b = int'(off >> GRAN_SHIFT);
        cur = 0;
        prev = 0;
        have_prev = 0;
        while (cur < b)
        begin
            s = tag_gran[cur];
            if (s == 0)
                return;
            prev = cur;
            have_prev = 1;
            cur += s;
        end
        if (cur != b || !tag_used[b])
            return;
        bs = tag_gran[b];
        used_sum -= bs * GRANULE_BYTES;
        live--;
        tag_used[b] = 0;
        n = b + bs;
        if (n < span && !tag_used[n])
        begin
            bs += tag_gran[n];
            tag_gran[b] = bs;
        end
        if (have_prev && !tag_used[prev])
            tag_gran[prev] = tag_gran[prev] + bs;
        st = ST_DONE;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        out_item_t got;
        if (!rst_n)
        begin
            base = '0;
            heap_reinit(16);
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HEAP_BASE)
                    base = cfg_data;
                else
                    heap_reinit(int'(cfg_data[4:0]));
            end
            // compare before predicting so a same-edge transfer sees the old queue
            if (pop && !empty)
            begin
                got = result;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: %h", got);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (got.payload_address !== e.payload_address)
                    begin
                        $error("payload_address exp %h got %h", e.payload_address,
                               got.payload_address);
                        fail_count++;
                    end
                    if (got.status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, got.status);
                        fail_count++;
                    end
                    if (got.used_bytes !== e.used_bytes)
                    begin
                        $error("used_bytes exp %0d got %0d", e.used_bytes, got.used_bytes);
                        fail_count++;
                    end
                    if (got.free_bytes !== e.free_bytes)
                    begin
                        $error("free_bytes exp %0d got %0d", e.free_bytes, got.free_bytes);
                        fail_count++;
                    end
                    if (got.alloc_count !== e.alloc_count)
                    begin
                        $error("alloc_count exp %0d got %0d", e.alloc_count,
                               got.alloc_count);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                e = '0;
                if (request.opcode == OP_ALLOC)
                    try_alloc(int'(request.request_bytes), e.status, e.payload_address);
                else
                    try_release(request.release_address, e.status);
                e.used_bytes = BYTES_W'(used_sum);
                e.free_bytes = BYTES_W'(span * GRANULE_BYTES - used_sum);
                e.alloc_count = COUNT_W'(live);
                expected_results.push_back(e);
            end
        end
    end

endmodule

>>> verif/tb_first_fit_heap_allocator.sv
// Testbench top for the first-fit heap allocator: clock, reset, stimulus and
// verdict. Depends on ffha_pkg, first_fit_heap_allocator and ffha_checker.
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              push = 0;
    logic              full;
    in_item_t          request = '0;
    logic              empty;
    logic              pop = 0;
    out_item_t         result;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic              cfg_index = REG_HEAP_BASE;
    logic [ADDR_W-1:0] cfg_data = '0;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    bit                calm = 0;
    bit                pop_on = 0;

    // live payloads handed out, used to aim frees at real blocks
    logic [ADDR_W-1:0] live_addrs[$];
    logic [ADDR_W-1:0] cur_base = '0;

    always #1 clk = ~clk;

    first_fit_heap_allocator dut (.*);

    ffha_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls except in calm stretches
    always @(posedge clk)
        pop <= rst_n && (calm || $urandom_range(99) >= 7);

    // track allocations as they come back so frees hit live blocks
    always @(posedge clk)
        if (pop && !empty && result.status == ST_DONE && result.payload_address != 0
            && live_addrs.size() < 4000)
            live_addrs.push_back(result.payload_address);

    // push stays high after a transfer; the next send or an idle cycle drops it
    task automatic send(input in_item_t it);
        while (!calm && $urandom_range(99) < 7)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        request <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic alloc_req(input int unsigned bytes);
        in_item_t it;
        it = '0;
        it.opcode = OP_ALLOC;
        it.request_bytes = REQ_W'(bytes);
        it.release_address = ADDR_W'({$urandom, $urandom});
        send(it);
    endtask

    task automatic free_req(input logic [ADDR_W-1:0] a);
        in_item_t it;
        it = '0;
        it.opcode = OP_FREE;
        it.request_bytes = REQ_W'($urandom);
        it.release_address = a;
        send(it);
    endtask

    task automatic drain_and_write(input logic idx, input logic [ADDR_W-1:0] val);
        push <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        if (idx == REG_HEAP_BASE)
            cur_base = val;
        else
            live_addrs.delete();
    endtask

    task automatic free_random_live();
        int k;
        logic [ADDR_W-1:0] a;
        if (live_addrs.size() == 0)
        begin
            free_req(cur_base + ADDR_W'(8));
            return;
        end
        k = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        free_req(a);
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 3) && (i < n / 3 + 60);
            r = $urandom_range(99);
            if (r < 45)
                alloc_req(r < 40 ? $urandom_range(1, 600) : $urandom_range(0, 65536));
            else if (r < 85)
                free_random_live();
            else if (r < 90)
                free_req(live_addrs.size() ? live_addrs[0] + ADDR_W'(16) : '0);
            else
                free_req(ADDR_W'({$urandom, $urandom}));
        end
        calm = 0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, rounding, no fit, bad frees
        alloc_req(0);
        alloc_req(1);
        alloc_req(4);
        alloc_req(5);
        alloc_req(20);
        alloc_req(21);
        alloc_req(65536);
        alloc_req(131071);
        free_req('0);
        free_req(48'hFFFF_FFFF_FFFF);
        free_req(ADDR_W'(12));
        free_req(ADDR_W'(8));
        free_req(ADDR_W'(8));
        free_req(ADDR_W'(40));
        free_req(ADDR_W'(72));
        alloc_req(65000);
        alloc_req(100);
        drain_and_write(REG_HEAP_PAGES, ADDR_W'(1));
        alloc_req(4084);
        alloc_req(4085);
        alloc_req(1);
        drain_and_write(REG_HEAP_PAGES, ADDR_W'(0));
        alloc_req(1);
        free_req(ADDR_W'(8));
        // base near the top so payload addresses wrap around past zero
        drain_and_write(REG_HEAP_BASE, 48'hFFFF_FFFF_F000);
        drain_and_write(REG_HEAP_PAGES, ADDR_W'(31));
        alloc_req(100);
        alloc_req(100);
        alloc_req(4000);
        random_phase(300);
        drain_and_write(REG_HEAP_BASE, ADDR_W'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000);
        drain_and_write(REG_HEAP_PAGES, ADDR_W'(2));
        random_phase(500);
        drain_and_write(REG_HEAP_BASE, ADDR_W'(0));
        drain_and_write(REG_HEAP_PAGES, ADDR_W'(16));
        random_phase(600);
        drain_and_write(REG_HEAP_BASE, 48'hAAAA_5555_A000);
        drain_and_write(REG_HEAP_PAGES, ADDR_W'(5));
        random_phase(400);
        push <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
